### design/assert_macros.svh
// Assertion macros shared by the design files.
// Depends on a clock named clk and a reset named rst in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// check on every edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### design/pcdf_pkg.sv
// Package for the per-client duplicate filter: sizes, constants, transfer types.
// No dependencies.
package pcdf_pkg;

  localparam int MAX_CLIENTS = 64;
  localparam int MAX_SEEN    = 32;

  localparam int CCOUNT_W = $clog2(MAX_CLIENTS + 1);
  localparam int CIDX_W   = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1;
  localparam int SCOUNT_W = $clog2(MAX_SEEN + 1);
  localparam int SEEN_DEPTH = MAX_CLIENTS * MAX_SEEN;
  localparam int SEEN_AW  = (SEEN_DEPTH > 1) ? $clog2(SEEN_DEPTH) : 1;
  localparam int CTAB_W   = 48;

  localparam logic [39:0] STOP_TEXT = 40'h73746F7000;

  typedef enum logic {
    OP_DATAGRAM = 1'b0,
    OP_TIMEOUT  = 1'b1
  } opcode_t;

  typedef struct packed {
    logic        opcode;
    logic [31:0] sender_addr;
    logic [15:0] sender_port;
    logic [31:0] msg_number;
    logic [39:0] text_head;
  } item_t;

  typedef struct packed {
    logic       send_ack;
    logic       new_client;
    logic [5:0] client_slot;
    logic       stop_seen;
    logic       overflow;
    logic       halted;
  } result_t;

endpackage

### design/pcdf_item_if.sv
// Input channel: datagram headers and timeout events.
// Depends on pcdf_pkg.
interface pcdf_item_if import pcdf_pkg::*; ();
  logic  valid;
  logic  ready;
  item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### design/pcdf_result_if.sv
// Output channel: one filter result per input item.
// Depends on pcdf_pkg.
interface pcdf_result_if import pcdf_pkg::*; ();
  logic    valid;
  logic    ready;
  result_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### design/pcdf_ram.sv
// Simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module pcdf_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AddrW-1:0] waddr,
  input  logic [Width-1:0] wdata,
  input  logic [AddrW-1:0] raddr,
  output logic [Width-1:0] rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/per_client_duplicate_filter.sv
// Per-client duplicate filter: client lookup and seen-number search.
// Depends on pcdf_pkg, pcdf_item_if, pcdf_result_if, pcdf_ram, assert_macros.svh.
//
// Channels: item (sink) carries a datagram header or a timeout event; result
// (source) returns exactly one result per item. Both transfer on valid and ready.
// A datagram looks the sender up in the client table, adding it when new and the
// table has room, then searches that client's seen numbers; a new number is
// acknowledged and recorded while the list has room. A full table or a full
// seen list sets overflow; the datagram is then acknowledged but not recorded.
// A timeout empties the client table. The searches make one compare a cycle
// against each RAM's read port.
// item.ready rises in the same cycle as the result is registered.
// One item is in work at a time; item.ready is high only between items.
// The result sits in an output register; the next item is taken while it waits,
// but that item's result is held back until the receiver takes the earlier one.
// Reset empties the client table, clears the halt and drops any pending result.
// The tables need no clearing pass: nothing is read before it is written.
// After a "stop" message every later item returns only the halted flag.
`include "assert_macros.svh"

module per_client_duplicate_filter import pcdf_pkg::*; (
  input logic           clk,
  input logic           rst,
  pcdf_item_if.sink     item,
  pcdf_result_if.source result
);

  typedef enum logic [2:0] {
    IDLE,
    CSRCH,
    CNT_WAIT,
    CNT_LD,
    SSRCH,
    NEWCL,
    SWRITE,
    FINISH
  } state_t;

  state_t              state;
  item_t               cur;
  logic [CCOUNT_W-1:0] client_count;
  logic                halted_flag;
  logic [CCOUNT_W-1:0] ci;
  logic                cpend;
  logic [CIDX_W-1:0]   cpend_idx;
  logic [CIDX_W-1:0]   slot;
  logic [SCOUNT_W-1:0] si;
  logic                spend;
  logic [SCOUNT_W-1:0] seen_cnt;
  logic [SEEN_AW-1:0]  seen_base;
  logic                f_ack;
  logic                f_fresh;
  logic                f_slot;
  logic                f_ovf;
  logic                f_hlt;
  logic                res_valid;
  result_t             res_data;

  logic [CTAB_W-1:0]   ctab_q;
  logic [SCOUNT_W-1:0] cnt_q;
  logic [31:0]         seen_q;
  logic                ctab_we;
  logic                cnt_we;
  logic [SCOUNT_W-1:0] cnt_wdata;
  logic                seen_we;
  logic [SEEN_AW-1:0]  seen_waddr;
  logic [SEEN_AW-1:0]  seen_raddr;
  logic                c_hit;
  logic                s_hit;
  logic                out_free;

  assign item.ready   = (state == IDLE);
  assign result.valid = res_valid;
  assign result.data  = res_data;
  assign out_free     = !res_valid || result.ready;

  assign c_hit = cpend && (ctab_q == {cur.sender_addr, cur.sender_port});
  assign s_hit = spend && (seen_q == cur.msg_number);

  assign ctab_we    = (state == NEWCL);
  assign cnt_we     = (state == NEWCL) || (state == SWRITE);
  assign cnt_wdata  = (state == NEWCL) ? SCOUNT_W'(1) : SCOUNT_W'(seen_cnt + 1'b1);
  assign seen_we    = cnt_we;
  assign seen_waddr = (state == NEWCL) ? seen_base
                                       : SEEN_AW'(seen_base + SEEN_AW'(seen_cnt));
  assign seen_raddr = SEEN_AW'(seen_base + SEEN_AW'(si));

  pcdf_ram #(.Width(CTAB_W), .Depth(MAX_CLIENTS)) u_ctab (
    .clk   (clk),
    .we    (ctab_we),
    .waddr (slot),
    .wdata ({cur.sender_addr, cur.sender_port}),
    .raddr (ci[CIDX_W-1:0]),
    .rdata (ctab_q)
  );

  pcdf_ram #(.Width(SCOUNT_W), .Depth(MAX_CLIENTS)) u_cnt (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (slot),
    .wdata (cnt_wdata),
    .raddr (slot),
    .rdata (cnt_q)
  );

  pcdf_ram #(.Width(32), .Depth(SEEN_DEPTH)) u_seen (
    .clk   (clk),
    .we    (seen_we),
    .waddr (seen_waddr),
    .wdata (cur.msg_number),
    .raddr (seen_raddr),
    .rdata (seen_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= IDLE;
      client_count <= '0;
      halted_flag  <= 1'b0;
      res_valid    <= 1'b0;
      cpend        <= 1'b0;
      spend        <= 1'b0;
    end else begin
      if (result.ready && (state != FINISH)) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (item.valid) begin
            cur     <= item.data;
            f_ack   <= 1'b0;
            f_fresh <= 1'b0;
            f_slot  <= 1'b0;
            f_ovf   <= 1'b0;
            f_hlt   <= halted_flag;
            ci      <= '0;
            cpend   <= 1'b0;
            if (halted_flag) begin
              state <= FINISH;
            end else if (item.data.opcode == OP_TIMEOUT) begin
              client_count <= '0;
              state        <= FINISH;
            end else begin
              state <= CSRCH;
            end
          end
        end
        CSRCH: begin
          if (c_hit) begin
            slot  <= cpend_idx;
            cpend <= 1'b0;
            state <= CNT_WAIT;
          end else if (ci < client_count) begin
            cpend     <= 1'b1;
            cpend_idx <= ci[CIDX_W-1:0];
            ci        <= ci + 1'b1;
          end else if (cpend) begin
            cpend <= 1'b0;
          end else if (client_count < CCOUNT_W'(MAX_CLIENTS)) begin
            slot         <= client_count[CIDX_W-1:0];
            seen_base    <= SEEN_AW'(client_count[CIDX_W-1:0] * MAX_SEEN);
            client_count <= client_count + 1'b1;
            state        <= NEWCL;
          end else begin
            f_ack <= 1'b1;
            f_ovf <= 1'b1;
            state <= FINISH;
          end
        end
        CNT_WAIT: begin
          seen_base <= SEEN_AW'(slot * MAX_SEEN);
          state     <= CNT_LD;
        end
        CNT_LD: begin
          seen_cnt <= cnt_q;
          si       <= '0;
          spend    <= 1'b0;
          f_slot   <= 1'b1;
          state    <= SSRCH;
        end
        SSRCH: begin
          if (s_hit) begin
            spend <= 1'b0;
            state <= FINISH;
          end else if (si < seen_cnt) begin
            spend <= 1'b1;
            si    <= si + 1'b1;
          end else if (spend) begin
            spend <= 1'b0;
          end else begin
            f_ack <= 1'b1;
            if (seen_cnt < SCOUNT_W'(MAX_SEEN)) begin
              state <= SWRITE;
            end else begin
              f_ovf <= 1'b1;
              state <= FINISH;
            end
          end
        end
        NEWCL: begin
          f_ack   <= 1'b1;
          f_fresh <= 1'b1;
          f_slot  <= 1'b1;
          state   <= FINISH;
        end
        SWRITE: begin
          state <= FINISH;
        end
        FINISH: begin
          if (out_free) begin
            res_valid            <= 1'b1;
            res_data.send_ack    <= f_ack;
            res_data.new_client  <= f_fresh;
            res_data.client_slot <= f_slot ? 6'(slot) : 6'd0;
            res_data.stop_seen   <= f_ack && (cur.text_head == STOP_TEXT);
            res_data.overflow    <= f_ovf;
            res_data.halted      <= f_hlt;
            if (f_ack && (cur.text_head == STOP_TEXT)) begin
              halted_flag <= 1'b1;
            end
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  `ASSERT_CLK(a_count_bound, client_count <= CCOUNT_W'(MAX_CLIENTS), "client count beyond table")
  `ASSERT_CLK(a_halt_sticky, halted_flag |=> halted_flag, "halt cleared without reset")
  `ASSERT_CLK(a_halt_on_stop, $rose(halted_flag) |-> res_valid && res_data.stop_seen, "halt without stop result")
  `ASSERT_CLK(a_cnt_bound, cnt_we |-> cnt_wdata <= SCOUNT_W'(MAX_SEEN), "seen count beyond list")

endmodule
